@@ design/clnw_pkg.sv @@
// Package with the types, codes and command tables of the character LCD nibble writer.
package clnw_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [5:0] COLUMNS_RESET = 6'd16;
  localparam logic [7:0] ROW_EVEN_BASE = 8'h80;
  localparam logic [7:0] ROW_ODD_BASE  = 8'hC0;
  localparam logic [7:0] NEWLINE_CHAR  = 8'd10;

  localparam logic [4:0] INIT_FIRST  = 5'd0;
  localparam logic [4:0] CLEAR_FIRST = 5'd12;
  localparam logic [4:0] SEQ_LAST    = 5'd17;

  localparam logic [4:0] STEP_GOTO_HI = 5'd0;
  localparam logic [4:0] STEP_GOTO_LO = 5'd1;
  localparam logic [4:0] STEP_DATA_HI = 5'd2;
  localparam logic [4:0] STEP_DATA_LO = 5'd3;

  typedef enum logic [1:0] {
    FUNC_INIT  = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_GOTO  = 2'd2,
    FUNC_PUT   = 2'd3
  } func_e;

  typedef enum logic {
    KIND_TABLE = 1'b0,
    KIND_BYTES = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [4:0] first_idx;
    logic [4:0] last_idx;
    logic [7:0] goto_byte;
    logic [7:0] data_byte;
  } clnw_entry_t;

  typedef struct packed {
    logic        valid;
    clnw_entry_t entry;
  } clnw_slot_t;

  function automatic logic [7:0] row_base(input logic [1:0] row, input logic [5:0] cols);
    logic [7:0] base;
    case (row)
      2'd0:    base = ROW_EVEN_BASE;
      2'd1:    base = ROW_ODD_BASE;
      2'd2:    base = ROW_EVEN_BASE + {2'b00, cols};
      default: base = ROW_ODD_BASE + {2'b00, cols};
    endcase
    return base;
  endfunction

  // Power-up nibbles 3,3,3,2, bytes 0x28 0x04 0x85 0x06, then clear bytes 0x02 0x0C 0x01.
  function automatic logic [3:0] seq_nibble(input logic [4:0] idx);
    logic [3:0] nib;
    case (idx)
      5'd0, 5'd1, 5'd2:                   nib = 4'h3;
      5'd3, 5'd4, 5'd13:                  nib = 4'h2;
      5'd5, 5'd8:                         nib = 4'h8;
      5'd7:                               nib = 4'h4;
      5'd9:                               nib = 4'h5;
      5'd11:                              nib = 4'h6;
      5'd15:                              nib = 4'hC;
      5'd17:                              nib = 4'h1;
      default:                            nib = 4'h0;
    endcase
    return nib;
  endfunction

endpackage

@@ design/clnw_if.sv @@
// Valid/ready channel interfaces for commands and for nibble writes.
interface clnw_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] char_code;
  logic [5:0] column;
  logic [1:0] row;

  modport source (output valid, output func, output char_code, output column,
                  output row, input ready);
  modport sink (input valid, input func, input char_code, input column,
                input row, output ready);
endinterface

interface clnw_nib_if;
  logic       valid;
  logic       ready;
  logic [3:0] nibble;
  logic       reg_select;
  logic       last;

  modport source (output valid, output nibble, output reg_select, output last,
                  input ready);
  modport sink (input valid, input nibble, input reg_select, input last,
                output ready);
endinterface

@@ design/char_lcd_nibble_writer.sv @@
// Top level of the character LCD nibble writer for a 4-bit controller bus.
//
//   channel   direction  beat payload
//   cmd_i     in         func, char_code, column, row
//   nib_o     out        nibble, reg_select, last
//   cfg       in         cfg_we_i, cfg_data_i (columns)
//
// Each nibble beat takes one cycle from the sequencer unless nib_o stalls; a put is
// two or four beats, a goto two, clear six, init eighteen; the sequencer sets the rate.
// Commands are taken while the queue has room, so the front end runs ahead of the bus.
// Reset clears the cursor, the queue and the output valid flag and sets columns to 16.
// A stalled nib_o holds its beat while the queue keeps absorbing commands.
module char_lcd_nibble_writer import clnw_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_data_i,
  clnw_cmd_if.sink   cmd_i,
  clnw_nib_if.source nib_o
);

  clnw_slot_t push;
  clnw_slot_t head;
  logic       q_full;
  logic       pop;

  clnw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd        (cmd_i),
    .q_full_i   (q_full),
    .push_o     (push)
  );

  clnw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  clnw_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .nib    (nib_o)
  );

endmodule

@@ design/clnw_front.sv @@
// Command front end: column register, cursor tracking and command classification.
module clnw_front import clnw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_data_i,
  clnw_cmd_if.sink    cmd,
  input  logic        q_full_i,
  output clnw_slot_t  push_o
);

  logic [5:0] columns_q;
  logic [6:0] col_q, col_d;
  logic [1:0] row_q, row_d;
  logic       accept;
  logic [1:0] row_next;
  logic [6:0] col_inc;
  clnw_entry_t entry;

  assign cmd.ready = !q_full_i;
  assign accept    = cmd.valid && cmd.ready;
  assign row_next  = row_q + 2'd1;
  assign col_inc   = col_q + 7'd1;

  always_comb begin
    col_d           = col_q;
    row_d           = row_q;
    entry.kind      = KIND_TABLE;
    entry.first_idx = INIT_FIRST;
    entry.last_idx  = SEQ_LAST;
    entry.goto_byte = row_base(cmd.row, columns_q) + {2'b00, cmd.column};
    entry.data_byte = cmd.char_code;
    unique case (func_e'(cmd.func))
      FUNC_INIT: begin
        col_d = '0;
        row_d = '0;
      end
      FUNC_CLEAR: begin
        entry.first_idx = CLEAR_FIRST;
        col_d           = '0;
        row_d           = '0;
      end
      FUNC_GOTO: begin
        entry.kind      = KIND_BYTES;
        entry.first_idx = STEP_GOTO_HI;
        entry.last_idx  = STEP_GOTO_LO;
        col_d           = {1'b0, cmd.column};
        row_d           = cmd.row;
      end
      default: begin
        entry.kind      = KIND_BYTES;
        entry.goto_byte = row_base(row_next, columns_q);
        if (cmd.char_code == NEWLINE_CHAR) begin
          entry.first_idx = STEP_GOTO_HI;
          entry.last_idx  = STEP_GOTO_LO;
          col_d           = '0;
          row_d           = row_next;
        end else if (col_inc > {1'b0, columns_q}) begin
          entry.first_idx = STEP_GOTO_HI;
          entry.last_idx  = STEP_DATA_LO;
          col_d           = 7'd1;
          row_d           = row_next;
        end else begin
          entry.first_idx = STEP_DATA_HI;
          entry.last_idx  = STEP_DATA_LO;
          col_d           = col_inc;
        end
      end
    endcase
  end

  assign push_o.valid = accept;
  assign push_o.entry = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= COLUMNS_RESET;
      col_q     <= '0;
      row_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        columns_q <= cfg_data_i;
      end
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

endmodule

@@ design/clnw_queue.sv @@
// Short queue of classified commands between the front end and the nibble sequencer.
module clnw_queue import clnw_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  clnw_slot_t push_i,
  input  logic       pop_i,
  output logic       full_o,
  output clnw_slot_t head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  clnw_entry_t     mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o       = cnt_q == CntFull;
  assign head_o.valid = cnt_q != '0;
  assign head_o.entry = mem_q[rd_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrMax) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrMax) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

@@ design/clnw_back.sv @@
// Nibble sequencer: expands queued commands into nibble beats through an output register.
module clnw_back import clnw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  clnw_slot_t  head_i,
  output logic        pop_o,
  clnw_nib_if.source  nib
);

  clnw_entry_t cur_q;
  logic        busy_q;
  logic [4:0]  idx_q;
  logic        ov_q;
  logic [3:0]  nib_q;
  logic        rs_q, last_q;
  logic        out_free, emit, is_last;
  logic [7:0]  sel_byte;
  logic [3:0]  nib_d;
  logic        rs_d;

  assign out_free = !ov_q || nib.ready;
  assign emit     = busy_q && out_free;
  assign is_last  = idx_q == cur_q.last_idx;
  assign pop_o    = head_i.valid && (!busy_q || (emit && is_last));

  assign sel_byte = idx_q[1] ? cur_q.data_byte : cur_q.goto_byte;

  always_comb begin
    if (cur_q.kind == KIND_TABLE) begin
      nib_d = seq_nibble(idx_q);
      rs_d  = 1'b0;
    end else begin
      nib_d = idx_q[0] ? sel_byte[3:0] : sel_byte[7:4];
      rs_d  = idx_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i.entry;
    end
    if (emit) begin
      nib_q  <= nib_d;
      rs_q   <= rs_d;
      last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= head_i.entry.first_idx;
      end else if (emit && is_last) begin
        busy_q <= 1'b0;
      end else if (emit) begin
        idx_q <= idx_q + 5'd1;
      end
      if (emit) begin
        ov_q <= 1'b1;
      end else if (nib.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign nib.valid      = ov_q;
  assign nib.nibble     = nib_q;
  assign nib.reg_select = rs_q;
  assign nib.last       = last_q;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the character LCD nibble writer: commands in, nibble beats checked.
module testbench import clnw_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS = 10;

  localparam logic [7:0] LCD_FUNCTION_SET = 8'h28;
  localparam logic [7:0] LCD_ENTRY_INIT   = 8'h04;
  localparam logic [7:0] LCD_INIT_EXTRA   = 8'h85;
  localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;
  localparam logic [7:0] LCD_HOME         = 8'h02;
  localparam logic [7:0] LCD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] LCD_CLEAR        = 8'h01;
  localparam logic [3:0] WAKE_NIBBLE      = 4'h3;
  localparam logic [3:0] FOUR_BIT_NIBBLE  = 4'h2;

  class nibble_scoreboard;
    typedef struct packed {
      logic [3:0] nibble;
      logic       reg_select;
      logic       last;
    } beat_t;

    beat_t      pending[$];
    logic [5:0] columns;
    logic [6:0] cursor_col;
    logic [1:0] cursor_row;
    int         mismatches;

    function new();
      columns    = COLUMNS_RESET;
      cursor_col = '0;
      cursor_row = '0;
      mismatches = 0;
    endfunction

    function void set_columns(logic [5:0] value);
      columns = value;
    endfunction

    function void push_nibble(logic [3:0] nib, logic rs);
      beat_t b;
      b.nibble     = nib;
      b.reg_select = rs;
      b.last       = 1'b0;
      pending.push_back(b);
    endfunction

    function void push_byte(logic [7:0] value, logic rs);
      push_nibble(value[7:4], rs);
      push_nibble(value[3:0], rs);
    endfunction

    function logic [7:0] line_base(logic [1:0] r);
      case (r)
        2'd0:    return ROW_EVEN_BASE;
        2'd1:    return ROW_ODD_BASE;
        2'd2:    return ROW_EVEN_BASE + {2'b00, columns};
        default: return ROW_ODD_BASE + {2'b00, columns};
      endcase
    endfunction

    function void push_goto(logic [5:0] col, logic [1:0] r);
      push_byte(line_base(r) + {2'b00, col}, 1'b0);
      cursor_col = {1'b0, col};
      cursor_row = r;
    endfunction

    function void push_clear();
      push_byte(LCD_HOME, 1'b0);
      push_byte(LCD_DISPLAY_ON, 1'b0);
      push_byte(LCD_CLEAR, 1'b0);
      cursor_col = '0;
      cursor_row = '0;
    endfunction

    function void note_command(func_e f, logic [7:0] ch, logic [5:0] col, logic [1:0] r);
      logic [6:0] next_col;
      beat_t      tail;
      case (f)
        FUNC_INIT: begin
          push_nibble(WAKE_NIBBLE, 1'b0);
          push_nibble(WAKE_NIBBLE, 1'b0);
          push_nibble(WAKE_NIBBLE, 1'b0);
          push_nibble(FOUR_BIT_NIBBLE, 1'b0);
          push_byte(LCD_FUNCTION_SET, 1'b0);
          push_byte(LCD_ENTRY_INIT, 1'b0);
          push_byte(LCD_INIT_EXTRA, 1'b0);
          push_byte(LCD_ENTRY_MODE, 1'b0);
          push_clear();
        end
        FUNC_CLEAR: begin
          push_clear();
        end
        FUNC_GOTO: begin
          push_goto(col, r);
        end
        default: begin
          if (ch == NEWLINE_CHAR) begin
            push_goto(6'd0, cursor_row + 2'd1);
          end else begin
            next_col = cursor_col + 7'd1;
            if (next_col > {1'b0, columns}) begin
              push_goto(6'd0, cursor_row + 2'd1);
              next_col = 7'd1;
            end
            cursor_col = next_col;
            push_byte(ch, 1'b1);
          end
        end
      endcase
      tail = pending.pop_back();
      tail.last = 1'b1;
      pending.push_back(tail);
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%s", what);
    endfunction

    function void check_beat(logic [3:0] nib, logic rs, logic last);
      beat_t exp_beat;
      if (pending.size() == 0) begin
        report($sformatf("unexpected beat: nibble %h rs %b last %b", nib, rs, last));
      end else begin
        exp_beat = pending.pop_front();
        if (exp_beat.nibble !== nib || exp_beat.reg_select !== rs || exp_beat.last !== last) begin
          report($sformatf("beat mismatch: expected nibble %h rs %b last %b, got %h %b %b",
                           exp_beat.nibble, exp_beat.reg_select, exp_beat.last, nib, rs, last));
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [5:0] cfg_data_i;

  clnw_cmd_if cmd_bus ();
  clnw_nib_if nib_bus ();

  nibble_scoreboard sb = new();

  int tx_idle_pct = 8;
  int rx_idle_pct = 48;
  int stall_request = 0;

  char_lcd_nibble_writer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd_bus),
    .nib_o      (nib_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int stall_left;
    stall_left = 0;
    nib_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (nib_bus.valid && nib_bus.ready) begin
        sb.check_beat(nib_bus.nibble, nib_bus.reg_select, nib_bus.last);
      end
      if (stall_request > 0) begin
        stall_left = stall_request;
        stall_request = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        nib_bus.ready <= 1'b0;
      end else begin
        nib_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_command(func_e f, logic [7:0] ch, logic [5:0] col, logic [1:0] r);
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_bus.valid     <= 1'b1;
    cmd_bus.func      <= f;
    cmd_bus.char_code <= ch;
    cmd_bus.column    <= col;
    cmd_bus.row       <= r;
    do @(posedge clk_i); while (!cmd_bus.ready);
    sb.note_command(f, ch, col, r);
  endtask

  task automatic send_put(logic [7:0] ch);
    send_command(FUNC_PUT, ch, 6'($urandom_range(63)), 2'($urandom_range(3)));
  endtask

  task automatic send_goto(logic [5:0] col, logic [1:0] r);
    send_command(FUNC_GOTO, 8'($urandom_range(255)), col, r);
  endtask

  task automatic random_command();
    int unsigned pick;
    logic [7:0]  ch;
    logic [5:0]  col;
    func_e       f;
    pick = $urandom_range(99);
    ch = 8'($urandom_range(255));
    if ($urandom_range(9) == 0) ch = NEWLINE_CHAR;
    if ($urandom_range(1) == 1 && sb.columns != 6'd0) col = 6'($urandom_range(sb.columns));
    else col = 6'($urandom_range(63));
    if (pick < 70) f = FUNC_PUT;
    else if (pick < 85) f = FUNC_GOTO;
    else if (pick < 93) f = FUNC_CLEAR;
    else f = FUNC_INIT;
    send_command(f, ch, col, 2'($urandom_range(3)));
  endtask

  task automatic drain();
    cmd_bus.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_columns(logic [5:0] value);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.set_columns(value);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic random_phase(int count);
    repeat (count) random_command();
  endtask

  initial begin
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_data_i        <= '0;
    cmd_bus.valid     <= 1'b0;
    cmd_bus.func      <= FUNC_INIT;
    cmd_bus.char_code <= '0;
    cmd_bus.column    <= '0;
    cmd_bus.row       <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_command(FUNC_INIT, 8'hFF, 6'd63, 2'd3);
    send_command(FUNC_CLEAR, 8'h00, 6'd0, 2'd0);
    send_goto(6'd0, 2'd0);
    send_goto(6'd63, 2'd3);
    send_goto(6'd5, 2'd1);
    send_goto(6'd7, 2'd2);
    send_put(8'h41);
    send_put(8'hFF);
    send_put(8'h00);
    send_put(NEWLINE_CHAR);
    send_put(NEWLINE_CHAR);
    send_goto(6'd15, 2'd0);
    send_put(8'h78);
    send_put(8'h79);

    write_columns(6'd1);
    send_goto(6'd0, 2'd3);
    send_put(8'h55);
    send_put(8'hAA);
    write_columns(6'd0);
    send_put(8'h30);
    send_put(8'h31);
    write_columns(6'd40);
    send_goto(6'd40, 2'd3);
    send_put(8'h7E);
    write_columns(6'd63);
    send_goto(6'd63, 2'd3);
    send_put(8'h80);
    send_command(FUNC_CLEAR, 8'h0A, 6'd21, 2'd2);

    write_columns(6'($urandom_range(1, 8)));
    random_phase(80);

    tx_idle_pct = 48;
    rx_idle_pct = 8;
    write_columns(6'd40);
    random_phase(80);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_columns(6'd16);
    stall_request = 300;
    repeat (40) send_put(8'($urandom_range(255)));
    write_columns(6'($urandom_range(63)));
    random_phase(80);

    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ char_lcd_nibble_writer.f @@
design/clnw_pkg.sv
design/clnw_if.sv
design/clnw_front.sv
design/clnw_queue.sv
design/clnw_back.sv
design/char_lcd_nibble_writer.sv
tb/testbench.sv
